### sv/gnssrx_pkg.sv
// Shared types, codes and character helpers for the GNSS receive byte front end.
`timescale 1ns / 1ps

package gnssrx_pkg;

   // UBX framing constants.
   localparam logic [7:0] UBX_SYNC_A  = 8'hB5;
   localparam logic [7:0] UBX_SYNC_B  = 8'h62;
   localparam logic [7:0] UBX_NAV     = 8'h01;
   localparam logic [7:0] UBX_LEAP_ID = 8'h26;
   localparam logic [15:0] UBX_LEAP_MIN_LEN = 16'd24;
   localparam logic [15:0] UBX_LEAP_BYTE    = 16'd9;
   localparam logic [15:0] UBX_VALID_BYTE   = 16'd23;

   // UBX deframer phases.
   localparam logic [3:0] PH_SYNC_A  = 4'd0;
   localparam logic [3:0] PH_SYNC_B  = 4'd1;
   localparam logic [3:0] PH_CLASS   = 4'd2;
   localparam logic [3:0] PH_ID      = 4'd3;
   localparam logic [3:0] PH_LEN_LO  = 4'd4;
   localparam logic [3:0] PH_LEN_HI  = 4'd5;
   localparam logic [3:0] PH_PAYLOAD = 4'd6;
   localparam logic [3:0] PH_CK_A    = 4'd7;
   localparam logic [3:0] PH_CK_B    = 4'd8;

   // NMEA characters.
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;

   localparam int unsigned SHORT_LIMIT = 10;

   // Sentence status codes.
   localparam logic [1:0] ST_ACCEPTED = 2'd0;
   localparam logic [1:0] ST_CHECKSUM = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;
   localparam logic [1:0] ST_SHORT    = 2'd3;

   // Sentence kind codes.
   localparam logic [2:0] KIND_OTHER = 3'd0;
   localparam logic [2:0] KIND_RMC   = 3'd1;
   localparam logic [2:0] KIND_GGA   = 3'd2;
   localparam logic [2:0] KIND_GSA   = 3'd3;
   localparam logic [2:0] KIND_ZDA   = 3'd4;

   typedef struct packed {
      logic        done;
      logic [7:0]  frame_class;
      logic [7:0]  frame_id;
      logic [15:0] frame_length;
      logic signed [7:0] leap_offset;
      logic        leap_valid;
   } ubx_result_type;

   typedef struct packed {
      logic        done;
      logic [1:0]  status;
      logic [2:0]  kind;
      logic [31:0] good_count;
      logic [31:0] bad_count;
   } nmea_result_type;

   // Returns {is_hex, nibble} for one character, either case.
   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

   // Characters one to five of the sentence, first character in the low byte.
   function automatic logic [2:0] classify(input logic [4:0][7:0] t);
      logic [2:0] k;
      k = KIND_OTHER;
      if (t[0] == 8'h47 && (t[1] == 8'h50 || t[1] == 8'h4E)) begin
         if (t[2] == 8'h52 && t[3] == 8'h4D && t[4] == 8'h43) begin
            k = KIND_RMC;
         end else if (t[2] == 8'h47 && t[3] == 8'h47 && t[4] == 8'h41) begin
            k = KIND_GGA;
         end else if (t[2] == 8'h47 && t[3] == 8'h53 && t[4] == 8'h41) begin
            k = KIND_GSA;
         end else if (t[2] == 8'h5A && t[3] == 8'h44 && t[4] == 8'h41) begin
            k = KIND_ZDA;
         end
      end
      return k;
   endfunction

endpackage

### sv/gnssrx_ubx.sv
// UBX deframer: tracks sync, header, payload and checksum bytes and latches leap seconds.
`timescale 1ns / 1ps

module gnssrx_ubx
   import gnssrx_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  logic [7:0]     rx_byte,
   output ubx_result_type result
);

   logic [3:0]  phase_ff, phase_in;
   logic [7:0]  class_ff, class_in;
   logic [7:0]  id_ff, id_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] index_ff, index_in;
   logic [7:0]  cand_leap_ff, cand_leap_in;
   logic        cand_valid_ff, cand_valid_in;
   logic [7:0]  leap_ff, leap_in;
   logic        leap_valid_ff, leap_valid_in;
   logic [15:0] index_next;

   assign index_next = index_ff + 16'd1;

   always_comb begin
      phase_in      = phase_ff;
      class_in      = class_ff;
      id_in         = id_ff;
      length_in     = length_ff;
      index_in      = index_ff;
      cand_leap_in  = cand_leap_ff;
      cand_valid_in = cand_valid_ff;
      leap_in       = leap_ff;
      leap_valid_in = leap_valid_ff;
      result        = '0;
      unique case (phase_ff)
         PH_SYNC_B: begin
            phase_in = (rx_byte == UBX_SYNC_B) ? PH_CLASS : PH_SYNC_A;
         end
         PH_CLASS: begin
            class_in = rx_byte;
            phase_in = PH_ID;
         end
         PH_ID: begin
            id_in    = rx_byte;
            phase_in = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            length_in = {8'd0, rx_byte};
            phase_in  = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            length_in = {rx_byte, length_ff[7:0]};
            index_in  = 16'd0;
            phase_in  = ({rx_byte, length_ff[7:0]} != 16'd0) ? PH_PAYLOAD : PH_CK_A;
         end
         PH_PAYLOAD: begin
            if (index_ff == UBX_LEAP_BYTE) begin
               cand_leap_in = rx_byte;
            end
            // Only bit 0 of the validity byte is ever used.
            if (index_ff == UBX_VALID_BYTE) begin
               cand_valid_in = rx_byte[0];
            end
            index_in = index_next;
            if (index_next >= length_ff) begin
               phase_in = PH_CK_A;
            end
         end
         PH_CK_A: begin
            phase_in = PH_CK_B;
         end
         PH_CK_B: begin
            if (class_ff == UBX_NAV && id_ff == UBX_LEAP_ID &&
                length_ff >= UBX_LEAP_MIN_LEN) begin
               leap_in       = cand_leap_ff;
               leap_valid_in = cand_valid_ff;
            end
            result.done         = 1'b1;
            result.frame_class  = class_ff;
            result.frame_id     = id_ff;
            result.frame_length = length_ff;
            phase_in            = PH_SYNC_A;
         end
         default: begin
            // Idle, and any unused phase, hunts for the first sync byte.
            phase_in = (rx_byte == UBX_SYNC_A) ? PH_SYNC_B : PH_SYNC_A;
         end
      endcase
      result.leap_offset = leap_in;
      result.leap_valid  = leap_valid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SYNC_A;
         class_ff      <= 8'd0;
         id_ff         <= 8'd0;
         length_ff     <= 16'd0;
         index_ff      <= 16'd0;
         cand_leap_ff  <= 8'd0;
         cand_valid_ff <= 1'b0;
         leap_ff       <= 8'd0;
         leap_valid_ff <= 1'b0;
      end else if (step) begin
         phase_ff      <= phase_in;
         class_ff      <= class_in;
         id_ff         <= id_in;
         length_ff     <= length_in;
         index_ff      <= index_in;
         cand_leap_ff  <= cand_leap_in;
         cand_valid_ff <= cand_valid_in;
         leap_ff       <= leap_in;
         leap_valid_ff <= leap_valid_in;
      end
   end

endmodule

### sv/gnssrx_nmea.sv
// NMEA framer: stores and checks one sentence, classifies it and keeps the counters.
`timescale 1ns / 1ps

module gnssrx_nmea
   import gnssrx_pkg::*;
#(
   parameter int SENTENCE_MAX = 128
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  logic [7:0]      rx_byte,
   output nmea_result_type result
);

   localparam int LEN_W = $clog2(SENTENCE_MAX);
   localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(SENTENCE_MAX - 1);
   localparam logic [LEN_W-1:0] LEN_SHORT = LEN_W'(SHORT_LIMIT);

   logic             open_ff, open_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             ovf_ff, ovf_in;
   logic [7:0]       xor_ff, xor_in;
   logic             star_ff, star_in;
   logic [1:0]       after_ff, after_in;
   logic [7:0]       hex_ff, hex_in;
   logic             hex_open_ff, hex_open_in;
   logic [4:0][7:0]  type_ff, type_in;
   logic [31:0]      good_ff, good_in;
   logic [31:0]      bad_ff, bad_in;
   logic [4:0]       nib;

   assign nib = hex_nibble(rx_byte);

   always_comb begin
      open_in     = open_ff;
      len_in      = len_ff;
      ovf_in      = ovf_ff;
      xor_in      = xor_ff;
      star_in     = star_ff;
      after_in    = after_ff;
      hex_in      = hex_ff;
      hex_open_in = hex_open_ff;
      type_in     = type_ff;
      good_in     = good_ff;
      bad_in      = bad_ff;
      result      = '0;

      // A dollar always restarts, dropping any open sentence silently.
      if (rx_byte == CH_DOLLAR) begin
         open_in     = 1'b1;
         len_in      = '0;
         ovf_in      = 1'b0;
         xor_in      = 8'd0;
         star_in     = 1'b0;
         after_in    = 2'd0;
         hex_in      = 8'd0;
         hex_open_in = 1'b0;
         type_in     = '0;
      end

      if (open_in) begin
         if (len_in < LEN_LIMIT) begin
            for (int i = 0; i < 5; i++) begin
               if (len_in == LEN_W'(i + 1)) begin
                  type_in[i] = rx_byte;
               end
            end
            if (len_in != '0) begin
               if (star_in) begin
                  if (after_in < 2'd2) begin
                     after_in = after_in + 2'd1;
                  end
                  if (hex_open_in) begin
                     if (nib[4]) begin
                        hex_in = {hex_in[3:0], nib[3:0]};
                     end else begin
                        hex_open_in = 1'b0;
                     end
                  end
               end else if (rx_byte == CH_STAR) begin
                  star_in     = 1'b1;
                  hex_open_in = 1'b1;
                  hex_in      = 8'd0;
                  after_in    = 2'd0;
               end else begin
                  xor_in = xor_in ^ rx_byte;
               end
            end
            len_in = len_in + LEN_W'(1);
         end else begin
            ovf_in = 1'b1;
         end

         if (rx_byte == CH_CR || rx_byte == CH_LF) begin
            open_in     = 1'b0;
            result.done = 1'b1;
            if (ovf_in) begin
               result.status = ST_OVERFLOW;
               bad_in        = bad_ff + 32'd1;
            end else if (len_in <= LEN_SHORT) begin
               result.status = ST_SHORT;
            end else if (star_in && after_in == 2'd2 && xor_in == hex_in) begin
               result.status = ST_ACCEPTED;
               result.kind   = classify(type_in);
               good_in       = good_ff + 32'd1;
            end else begin
               result.status = ST_CHECKSUM;
               bad_in        = bad_ff + 32'd1;
            end
         end
      end
      result.good_count = good_in;
      result.bad_count  = bad_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff     <= 1'b0;
         len_ff      <= '0;
         ovf_ff      <= 1'b0;
         xor_ff      <= 8'd0;
         star_ff     <= 1'b0;
         after_ff    <= 2'd0;
         hex_ff      <= 8'd0;
         hex_open_ff <= 1'b0;
         type_ff     <= '0;
         good_ff     <= 32'd0;
         bad_ff      <= 32'd0;
      end else if (step) begin
         open_ff     <= open_in;
         len_ff      <= len_in;
         ovf_ff      <= ovf_in;
         xor_ff      <= xor_in;
         star_ff     <= star_in;
         after_ff    <= after_in;
         hex_ff      <= hex_in;
         hex_open_ff <= hex_open_in;
         type_ff     <= type_in;
         good_ff     <= good_in;
         bad_ff      <= bad_in;
      end
   end

endmodule

### sv/gnss_receive_byte_front_end.sv
// Top level of the GNSS receive byte front end: input register, deframers, result register.
`timescale 1ns / 1ps

// Each accepted request carries one byte from the GNSS serial link and yields exactly one
// result, in order. The byte lands in an input register; when it moves on, the UBX deframer
// and the NMEA framer update their state from it and the result register captures the
// outcome, so one request can be taken every cycle while rsp_stall stays low. The result
// register and the input register decouple the two sides: a new request is taken while a
// finished result still waits, and req_stall rises only when both registers are full and
// rsp_stall is high. Frame fields are zero unless frame_done is set, status and kind are
// zero unless sentence_done is set, and the leap data and sentence counters show their
// values after the byte. SENTENCE_MAX bounds the stored sentence length (at most
// SENTENCE_MAX-1 characters, the '$' and the ending CR or LF included).
module gnss_receive_byte_front_end
   import gnssrx_pkg::*;
#(
   parameter int SENTENCE_MAX = 128
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_rx_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_sentence_done,
   output logic [1:0]        rsp_sentence_status,
   output logic [2:0]        rsp_sentence_kind,
   output logic              rsp_frame_done,
   output logic [7:0]        rsp_frame_class,
   output logic [7:0]        rsp_frame_id,
   output logic [15:0]       rsp_frame_length,
   output logic signed [7:0] rsp_leap_offset,
   output logic              rsp_leap_offset_valid,
   output logic [31:0]       rsp_good_sentences,
   output logic [31:0]       rsp_bad_sentences
);

   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff;
   logic            out_valid_ff, out_valid_in;
   logic            advance;
   logic            req_take;
   ubx_result_type  ubx_res;
   nmea_result_type nmea_res;
   ubx_result_type  ubx_ff;
   nmea_result_type nmea_ff;

   // The held byte moves on whenever the result register is empty or being emptied.
   assign advance     = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !advance;
   assign req_take    = req_valid && !req_stall;
   assign in_valid_in = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   gnssrx_ubx u_ubx (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .result  (ubx_res)
   );

   gnssrx_nmea #(
      .SENTENCE_MAX (SENTENCE_MAX)
   ) u_nmea (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .result  (nmea_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance) begin
         ubx_ff  <= ubx_res;
         nmea_ff <= nmea_res;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_sentence_done     = nmea_ff.done;
   assign rsp_sentence_status   = nmea_ff.status;
   assign rsp_sentence_kind     = nmea_ff.kind;
   assign rsp_frame_done        = ubx_ff.done;
   assign rsp_frame_class       = ubx_ff.frame_class;
   assign rsp_frame_id          = ubx_ff.frame_id;
   assign rsp_frame_length      = ubx_ff.frame_length;
   assign rsp_leap_offset       = ubx_ff.leap_offset;
   assign rsp_leap_offset_valid = ubx_ff.leap_valid;
   assign rsp_good_sentences    = nmea_ff.good_count;
   assign rsp_bad_sentences     = nmea_ff.bad_count;

endmodule

### sv/gnssrx_checker.sv
// Port-level checker for the GNSS receive byte front end, bound to the top level.
`timescale 1ns / 1ps

module gnssrx_checker
   import gnssrx_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic              rsp_sentence_done,
   input logic [1:0]        rsp_sentence_status,
   input logic [2:0]        rsp_sentence_kind,
   input logic              rsp_frame_done,
   input logic [7:0]        rsp_frame_class,
   input logic [7:0]        rsp_frame_id,
   input logic [15:0]       rsp_frame_length,
   input logic signed [7:0] rsp_leap_offset,
   input logic              rsp_leap_offset_valid,
   input logic [31:0]       rsp_good_sentences,
   input logic [31:0]       rsp_bad_sentences
);

   logic        rsp_take;
   logic [31:0] last_good_ff;
   logic [31:0] last_bad_ff;
   logic [31:0] good_expect;
   logic [31:0] bad_expect;

   assign rsp_take = rsp_valid && !rsp_stall;

   // Counters move only with the sentence results of the same request.
   assign good_expect = last_good_ff +
      32'(rsp_sentence_done && rsp_sentence_status == ST_ACCEPTED);
   assign bad_expect = last_bad_ff +
      32'(rsp_sentence_done && (rsp_sentence_status == ST_CHECKSUM ||
                                rsp_sentence_status == ST_OVERFLOW));

   always_ff @(posedge clock) begin
      if (reset) begin
         last_good_ff <= 32'd0;
         last_bad_ff  <= 32'd0;
      end else if (rsp_take) begin
         last_good_ff <= rsp_good_sentences;
         last_bad_ff  <= rsp_bad_sentences;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_good_sentences) &&
         $stable(rsp_sentence_done) && $stable(rsp_frame_done) && $stable(rsp_leap_offset) &&
         $stable(rsp_leap_offset_valid))
      else $error("stalled response changed");

   a_sentence_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (!rsp_sentence_done || rsp_sentence_status != ST_ACCEPTED) |->
         rsp_sentence_kind == KIND_OTHER &&
         (rsp_sentence_done || rsp_sentence_status == ST_ACCEPTED))
      else $error("sentence status or kind set without an accepted sentence");

   a_frame_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_done |->
         rsp_frame_class == 8'd0 && rsp_frame_id == 8'd0 && rsp_frame_length == 16'd0)
      else $error("frame fields set without a completed frame");

   a_good_count: assert property (@(posedge clock) disable iff (reset)
      rsp_take |-> rsp_good_sentences == good_expect)
      else $error("good sentence counter out of step with results");

   a_bad_count: assert property (@(posedge clock) disable iff (reset)
      rsp_take |-> rsp_bad_sentences == bad_expect)
      else $error("bad sentence counter out of step with results");

endmodule

bind gnss_receive_byte_front_end gnssrx_checker u_gnssrx_checker (.*);

### sim/tb_gnss_receive_byte_front_end.sv
// Self-checking testbench for the GNSS receive byte front end, with its own byte-level predictor.
`timescale 1ns / 1ps

module tb_gnss_receive_byte_front_end;
   import gnssrx_pkg::*;

   localparam int SENTENCE_MAX = 128;
   localparam int RESET_CYCLES = 9;
   localparam int RANDOM_ITEMS = 650;
   localparam int QUIET_ITEMS  = 80;
   localparam int HOLD_AT      = 150;
   localparam int LONG_HOLD    = 60;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 250000;

   typedef struct packed {
      logic              sentence_done;
      logic [1:0]        sentence_status;
      logic [2:0]        sentence_kind;
      logic              frame_done;
      logic [7:0]        frame_class;
      logic [7:0]        frame_id;
      logic [15:0]       frame_length;
      logic signed [7:0] leap_offset;
      logic              leap_offset_valid;
      logic [31:0]       good_sentences;
      logic [31:0]       bad_sentences;
   } byte_outcome_type;

   typedef struct packed {
      logic [7:0]       rx_byte;
      logic             typed;
      byte_outcome_type outcome;
   } directed_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [7:0]        req_rx_byte = 8'h00;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_sentence_done;
   logic [1:0]        rsp_sentence_status;
   logic [2:0]        rsp_sentence_kind;
   logic              rsp_frame_done;
   logic [7:0]        rsp_frame_class;
   logic [7:0]        rsp_frame_id;
   logic [15:0]       rsp_frame_length;
   logic signed [7:0] rsp_leap_offset;
   logic              rsp_leap_offset_valid;
   logic [31:0]       rsp_good_sentences;
   logic [31:0]       rsp_bad_sentences;

   gnss_receive_byte_front_end #(.SENTENCE_MAX(SENTENCE_MAX)) DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_rx_byte           (req_rx_byte),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_sentence_done     (rsp_sentence_done),
      .rsp_sentence_status   (rsp_sentence_status),
      .rsp_sentence_kind     (rsp_sentence_kind),
      .rsp_frame_done        (rsp_frame_done),
      .rsp_frame_class       (rsp_frame_class),
      .rsp_frame_id          (rsp_frame_id),
      .rsp_frame_length      (rsp_frame_length),
      .rsp_leap_offset       (rsp_leap_offset),
      .rsp_leap_offset_valid (rsp_leap_offset_valid),
      .rsp_good_sentences    (rsp_good_sentences),
      .rsp_bad_sentences     (rsp_bad_sentences)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predictor state for the NMEA framer.
   logic       nm_open = 1'b0;
   int         nm_len = 0;
   logic       nm_over = 1'b0;
   logic [7:0] nm_xor = 8'h00;
   logic       nm_star = 1'b0;
   logic [1:0] nm_after = 2'd0;
   logic [7:0] nm_hex = 8'h00;
   logic       nm_hex_live = 1'b0;
   logic [7:0] nm_head [5] = '{default: 8'h00};

   // Predictor state for the UBX deframer and the latched leap data.
   logic [3:0]  ubx_phase = PH_SYNC_A;
   logic [7:0]  ubx_cls = 8'h00;
   logic [7:0]  ubx_id = 8'h00;
   logic [15:0] ubx_len = 16'h0000;
   logic [15:0] ubx_pos = 16'h0000;
   logic [7:0]  ubx_leap_byte = 8'h00;
   logic [7:0]  ubx_valid_byte = 8'h00;
   logic [7:0]  leap_now = 8'h00;
   logic        leap_ok = 1'b0;
   logic [31:0] good_cnt = 32'd0;
   logic [31:0] bad_cnt = 32'd0;

   byte_outcome_type expected_outcomes [$];
   logic [7:0]       byte_stream [$];

   logic             offer_typed = 1'b0;
   byte_outcome_type offer_outcome = '0;
   logic             quiet_tail = 1'b0;
   logic             long_hold_done = 1'b0;
   int               stall_left = 0;
   int               failures = 0;
   int               requests_taken = 0;
   int               results_seen = 0;
   int               frames_seen = 0;
   int               status_seen [4] = '{default: 0};
   int               cycle_count = 0;

   // Rows with the typed flag set carry their outcome; the rest use the predictor's, and every row steps the predictor.
   directed_row_type directed_rows [25] = '{
      '{8'h00, 1'b1, '0},
      '{8'hFF, 1'b1, '0},
      '{UBX_SYNC_A, 1'b0, '0},
      '{UBX_SYNC_B, 1'b0, '0},
      '{8'h0A, 1'b0, '0},
      '{8'h0B, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h11, 1'b0, '0},
      '{8'h22, 1'b1, '{frame_done: 1'b1, frame_class: 8'h0A, frame_id: 8'h0B, default: '0}},
      '{CH_DOLLAR, 1'b0, '0},
      '{CH_STAR, 1'b0, '0},
      '{CH_CR, 1'b1, '{sentence_done: 1'b1, sentence_status: ST_SHORT, default: '0}},
      '{CH_DOLLAR, 1'b0, '0},
      '{"0", 1'b0, '0},
      '{"1", 1'b0, '0},
      '{"2", 1'b0, '0},
      '{"3", 1'b0, '0},
      '{"4", 1'b0, '0},
      '{"5", 1'b0, '0},
      '{"6", 1'b0, '0},
      '{"7", 1'b0, '0},
      '{"8", 1'b0, '0},
      '{"9", 1'b0, '0},
      '{CH_LF, 1'b1, '{sentence_done: 1'b1, sentence_status: ST_CHECKSUM,
                       bad_sentences: 32'd1, default: '0}}
   };

   function automatic byte_outcome_type predict_byte(input logic [7:0] c);
      byte_outcome_type r;
      int               pos;
      int               digit;
      r = '0;

      case (ubx_phase)
         PH_SYNC_B: ubx_phase = (c == UBX_SYNC_B) ? PH_CLASS : PH_SYNC_A;
         PH_CLASS: begin
            ubx_cls = c;
            ubx_phase = PH_ID;
         end
         PH_ID: begin
            ubx_id = c;
            ubx_phase = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            ubx_len = {8'h00, c};
            ubx_phase = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            ubx_len[15:8] = c;
            ubx_pos = 16'h0000;
            ubx_phase = (ubx_len != 16'h0000) ? PH_PAYLOAD : PH_CK_A;
         end
         PH_PAYLOAD: begin
            if (ubx_pos == UBX_LEAP_BYTE) ubx_leap_byte = c;
            if (ubx_pos == UBX_VALID_BYTE) ubx_valid_byte = c;
            ubx_pos = ubx_pos + 16'd1;
            if (ubx_pos >= ubx_len) ubx_phase = PH_CK_A;
         end
         PH_CK_A: ubx_phase = PH_CK_B;
         PH_CK_B: begin
            if (ubx_cls == UBX_NAV && ubx_id == UBX_LEAP_ID && ubx_len >= UBX_LEAP_MIN_LEN) begin
               leap_now = ubx_leap_byte;
               leap_ok = ubx_valid_byte[0];
            end
            r.frame_done = 1'b1;
            r.frame_class = ubx_cls;
            r.frame_id = ubx_id;
            r.frame_length = ubx_len;
            ubx_phase = PH_SYNC_A;
         end
         default: ubx_phase = (c == UBX_SYNC_A) ? PH_SYNC_B : PH_SYNC_A;
      endcase

      if (c == CH_DOLLAR) begin
         nm_open = 1'b1;
         nm_len = 0;
         nm_over = 1'b0;
         nm_xor = 8'h00;
         nm_star = 1'b0;
         nm_after = 2'd0;
         nm_hex = 8'h00;
         nm_hex_live = 1'b0;
         nm_head = '{default: 8'h00};
      end

      if (nm_open) begin
         if (nm_len < SENTENCE_MAX - 1) begin
            pos = nm_len;
            nm_len++;
            if (pos >= 1 && pos <= 5) nm_head[pos - 1] = c;
            if (pos >= 1) begin
               if (nm_star) begin
                  if (nm_after < 2'd2) nm_after++;
                  if (nm_hex_live) begin
                     if (c >= "0" && c <= "9") digit = c - "0";
                     else if (c >= "a" && c <= "f") digit = c - "a" + 10;
                     else if (c >= "A" && c <= "F") digit = c - "A" + 10;
                     else digit = -1;
                     if (digit >= 0) nm_hex = {nm_hex[3:0], digit[3:0]};
                     else nm_hex_live = 1'b0;
                  end
               end else if (c == CH_STAR) begin
                  nm_star = 1'b1;
                  nm_hex_live = 1'b1;
                  nm_hex = 8'h00;
                  nm_after = 2'd0;
               end else begin
                  nm_xor ^= c;
               end
            end
         end else begin
            nm_over = 1'b1;
         end

         if (c == CH_LF || c == CH_CR) begin
            nm_open = 1'b0;
            r.sentence_done = 1'b1;
            if (nm_over) begin
               r.sentence_status = ST_OVERFLOW;
               bad_cnt++;
            end else if (nm_len <= SHORT_LIMIT) begin
               r.sentence_status = ST_SHORT;
            end else if (nm_star && nm_after >= 2'd2 && nm_xor == nm_hex) begin
               r.sentence_status = ST_ACCEPTED;
               if (nm_head[0] == "G" && (nm_head[1] == "P" || nm_head[1] == "N")) begin
                  case ({nm_head[2], nm_head[3], nm_head[4]})
                     "RMC": r.sentence_kind = KIND_RMC;
                     "GGA": r.sentence_kind = KIND_GGA;
                     "GSA": r.sentence_kind = KIND_GSA;
                     "ZDA": r.sentence_kind = KIND_ZDA;
                     default: r.sentence_kind = KIND_OTHER;
                  endcase
               end
               good_cnt++;
            end else begin
               r.sentence_status = ST_CHECKSUM;
               bad_cnt++;
            end
         end
      end

      r.leap_offset = leap_now;
      r.leap_offset_valid = leap_ok;
      r.good_sentences = good_cnt;
      r.bad_sentences = bad_cnt;
      return r;
   endfunction

   task automatic check_field(input string name, input logic signed [63:0] want,
                              input logic signed [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      byte_outcome_type want;
      byte_outcome_type seen;
      byte_outcome_type predicted;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            seen = '{rsp_sentence_done, rsp_sentence_status, rsp_sentence_kind, rsp_frame_done,
                     rsp_frame_class, rsp_frame_id, rsp_frame_length, rsp_leap_offset,
                     rsp_leap_offset_valid, rsp_good_sentences, rsp_bad_sentences};
            results_seen++;
            if (expected_outcomes.size() == 0) begin
               $error("result arrived with no request outstanding");
               failures++;
            end else begin
               want = expected_outcomes.pop_front();
               check_field("sentence_done", want.sentence_done, seen.sentence_done);
               check_field("sentence_status", want.sentence_status, seen.sentence_status);
               check_field("sentence_kind", want.sentence_kind, seen.sentence_kind);
               check_field("frame_done", want.frame_done, seen.frame_done);
               check_field("frame_class", want.frame_class, seen.frame_class);
               check_field("frame_id", want.frame_id, seen.frame_id);
               check_field("frame_length", want.frame_length, seen.frame_length);
               check_field("leap_offset", want.leap_offset, seen.leap_offset);
               check_field("leap_offset_valid", want.leap_offset_valid, seen.leap_offset_valid);
               check_field("good_sentences", want.good_sentences, seen.good_sentences);
               check_field("bad_sentences", want.bad_sentences, seen.bad_sentences);
               if (want.frame_done) frames_seen++;
               if (want.sentence_done) status_seen[want.sentence_status]++;
            end
         end
         if (req_valid && !req_stall) begin
            predicted = predict_byte(req_rx_byte);
            expected_outcomes.push_back(offer_typed ? offer_outcome : predicted);
            requests_taken++;
         end
      end
   end

   // Result side: random stall bursts, plus one long hold-off that backs the block up.
   always @(negedge clock) begin
      if (!long_hold_done && results_seen >= HOLD_AT) begin
         long_hold_done = 1'b1;
         stall_left = LONG_HOLD;
      end else if (stall_left == 0 && !quiet_tail && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 11);
      end
      rsp_stall <= (stall_left != 0) && !reset;
      if (stall_left != 0) stall_left--;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timed out after %0d cycles with %0d results outstanding", cycle_count,
               expected_outcomes.size());
      $display("Regression FAIL");
      $finish;
   end

   function automatic logic [7:0] text_char();
      logic [7:0] c;
      c = 8'($urandom_range(32, 126));
      if (c == CH_DOLLAR || c == CH_STAR) c = ",";
      return c;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n, input logic lower);
      // 0x57 and 0x37 are 'a' and 'A' less ten.
      if (n < 4'd10) return "0" + {4'h0, n};
      return {4'h0, n} + (lower ? 8'h57 : 8'h37);
   endfunction

   // Appends one sentence: mostly well formed, sometimes damaged or with odd checksum digits.
   task automatic add_sentence(input int field_len, input logic damaged);
      logic [7:0] sum;
      logic [7:0] c;
      logic [7:0] head [5];
      int         form;
      logic       lower;
      sum = 8'h00;
      head[0] = ($urandom_range(0, 7) == 0) ? text_char() : "G";
      case ($urandom_range(0, 5))
         0, 1, 2: head[1] = "P";
         3, 4: head[1] = "N";
         default: head[1] = text_char();
      endcase
      case ($urandom_range(0, 6))
         0: {head[2], head[3], head[4]} = "RMC";
         1: {head[2], head[3], head[4]} = "GGA";
         2: {head[2], head[3], head[4]} = "GSA";
         3: {head[2], head[3], head[4]} = "ZDA";
         4: {head[2], head[3], head[4]} = "GSV";
         default: begin
            head[2] = text_char();
            head[3] = text_char();
            head[4] = text_char();
         end
      endcase
      byte_stream.push_back(CH_DOLLAR);
      foreach (head[i]) begin
         byte_stream.push_back(head[i]);
         sum ^= head[i];
      end
      repeat (field_len) begin
         c = text_char();
         byte_stream.push_back(c);
         sum ^= c;
      end
      form = $urandom_range(0, 19);
      lower = 1'($urandom_range(0, 1));
      if (form != 0) begin
         byte_stream.push_back(CH_STAR);
         if (damaged) sum ^= 8'h01 << $urandom_range(0, 7);
         // An extra leading digit is shifted out; only the low 8 bits count.
         if (form == 2) byte_stream.push_back(hex_char(4'($urandom_range(0, 15)), lower));
         if (form == 3) begin
            byte_stream.push_back(hex_char(sum[3:0], lower));
         end else if (form != 1) begin
            byte_stream.push_back(hex_char(sum[7:4], lower));
            byte_stream.push_back(hex_char(sum[3:0], lower));
         end
         if (form == 4) begin
            byte_stream.push_back(",");
            byte_stream.push_back(text_char());
         end
      end
      case ($urandom_range(0, 2))
         0: byte_stream.push_back(CH_CR);
         1: byte_stream.push_back(CH_LF);
         default: begin
            byte_stream.push_back(CH_CR);
            byte_stream.push_back(CH_LF);
         end
      endcase
   endtask

   task automatic add_ubx_frame(input int frame_len, input logic leap_frame);
      logic [15:0] len;
      logic [7:0]  c;
      len = 16'(frame_len);
      byte_stream.push_back(UBX_SYNC_A);
      byte_stream.push_back(UBX_SYNC_B);
      byte_stream.push_back(leap_frame ? UBX_NAV : 8'($urandom_range(0, 255)));
      byte_stream.push_back(leap_frame ? UBX_LEAP_ID : 8'($urandom_range(0, 255)));
      byte_stream.push_back(len[7:0]);
      byte_stream.push_back(len[15:8]);
      for (int i = 0; i < frame_len; i++) begin
         c = 8'($urandom_range(0, 255));
         if (i == UBX_LEAP_BYTE) begin
            case ($urandom_range(0, 3))
               0: c = 8'h80;
               1: c = 8'h7F;
               default: c = 8'($urandom_range(0, 255));
            endcase
         end
         byte_stream.push_back(c);
      end
      byte_stream.push_back(8'($urandom_range(0, 255)));
      byte_stream.push_back(8'($urandom_range(0, 255)));
   endtask

   // Called at a falling edge; returns at the falling edge after the request is taken.
   task automatic offer_byte(input logic [7:0] rx, input logic typed,
                             input byte_outcome_type outcome);
      if (!quiet_tail && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= rx;
      offer_typed <= typed;
      offer_outcome <= outcome;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      int   counted;
      int   seq;
      int   pick;
      logic countable;
      counted = 0;
      seq = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         offer_byte(directed_rows[i].rx_byte, directed_rows[i].typed, directed_rows[i].outcome);
      end

      while (counted < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         countable = 1'b1;
         if (seq == 3) begin
            // Payload past 256 bytes must still end the frame.
            add_ubx_frame($urandom_range(257, 300), 1'b0);
         end else if (seq == 8) begin
            add_sentence($urandom_range(120, 130), 1'b0);
         end else if (pick < 2) begin
            // Lengths around the storage limit.
            add_sentence($urandom_range(112, 125), 1'b0);
         end else if (pick < 45) begin
            add_sentence($urandom_range(0, 40), $urandom_range(0, 6) == 0);
         end else if (pick < 58) begin
            add_ubx_frame($urandom_range(22, 28), 1'b1);
         end else if (pick < 70) begin
            add_ubx_frame($urandom_range(0, 20), 1'b0);
         end else if (pick < 76) begin
            // Sentence cut off; a later dollar drops it without a result.
            byte_stream.push_back(CH_DOLLAR);
            repeat ($urandom_range(0, 12)) byte_stream.push_back(text_char());
         end else if (pick < 80) begin
            byte_stream.push_back(UBX_SYNC_A);
            byte_stream.push_back($urandom_range(0, 1) ? UBX_SYNC_A : text_char());
         end else begin
            countable = 1'b0;
            repeat ($urandom_range(1, 8)) byte_stream.push_back(8'($urandom_range(0, 255)));
         end

         while (byte_stream.size() != 0) begin
            offer_byte(byte_stream.pop_front(), 1'b0, '0);
            if (countable) counted++;
            if (!quiet_tail && counted >= RANDOM_ITEMS - QUIET_ITEMS) quiet_tail <= 1'b1;
         end

         if (seq == 20 || pick == 99) begin
            req_valid <= 1'b0;
            do @(negedge clock); while (expected_outcomes.size() != 0);
         end
         seq++;
      end

      req_valid <= 1'b0;
      while (expected_outcomes.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Drove %0d bytes in %0d cycles; %0d UBX frames completed.",
               requests_taken, cycle_count, frames_seen);
      $display("Sentences closed: %0d accepted, %0d checksum, %0d overflow, %0d too short.",
               status_seen[ST_ACCEPTED], status_seen[ST_CHECKSUM], status_seen[ST_OVERFLOW],
               status_seen[ST_SHORT]);
      if (failures == 0 && expected_outcomes.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
